>>> src/adcsr_pkg.sv
package adcsr_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_PROBE = 3'd1,
        PH_WRITE = 3'd2,
        PH_POLL  = 3'd3,
        PH_READ  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ACT_PROBE = 3'd0,
        ACT_WRITE = 3'd1,
        ACT_POLL  = 3'd2,
        ACT_CONV  = 3'd3,
        ACT_DONE  = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        FN_INIT     = 2'd0,
        FN_PRESENCE = 2'd1,
        FN_READ     = 2'd2,
        FN_BUS      = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        REG_RETRY_BASE = 2'd0,
        REG_RETRY_MAX  = 2'd1,
        REG_CONV_TMO   = 2'd2,
        REG_MAX_CHAN   = 2'd3
    } reg_index_t;

    localparam logic [15:0] RETRY_BASE_RST = 16'd500;
    localparam logic [21:0] RETRY_MAX_RST  = 22'd30000;
    localparam logic [15:0] CONV_TMO_RST   = 16'd20;
    localparam logic [1:0]  MAX_CHAN_RST   = 2'd3;

    localparam logic [2:0]  MAX_SHIFT      = 3'd6;
    localparam logic [7:0]  ERR_SAT        = 8'hFF;

    // single-shot start, OS bit, PGA, single-shot mode, data rate, comparator off
    localparam logic [1:0]  CFG_HI_BITS    = 2'b11;
    localparam logic [11:0] CFG_LO_BITS    = 12'h383;

    function automatic logic [15:0] word_for(input logic [1:0] ch);
        word_for = {CFG_HI_BITS, ch, CFG_LO_BITS};
    endfunction

endpackage

>>> src/adc_single_shot_read_with_backoff_unit.sv
// A result is registered and shown in the cycle after its input transaction is accepted.
// Throughput: one input transaction per cycle; the output register frees the
// input side whenever it is empty or being taken in the same cycle.
// Reset (rst_n, async, active low): idle, no presence, error count and
// deadlines cleared, configuration registers back to their defaults.
module adc_single_shot_read_with_backoff_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [21:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [2:0]         channel,
    input  logic [31:0]        now_ms,
    input  logic               bus_ok,
    input  logic [15:0]        bus_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         action,
    output logic [15:0]        config_word,
    output logic               done_ok,
    output logic               present,
    output logic signed [15:0] sample
);

    logic [15:0] retry_base_reg;
    logic [21:0] retry_max_reg;
    logic [15:0] conv_tmo_reg;
    logic [1:0]  max_chan_reg;

    adcsr_pkg::phase_t phase_reg, phase_next;
    adcsr_pkg::func_t  requester_reg, requester_next;
    logic        present_reg, present_next;
    logic [7:0]  err_cnt_reg, err_cnt_next;
    logic [31:0] next_probe_reg, next_probe_next;
    logic [31:0] conv_start_reg, conv_start_next;
    logic [1:0]  chan_reg, chan_next;

    logic        out_valid_reg;
    adcsr_pkg::action_t action_reg, action_next;
    logic [15:0] word_reg, word_next;
    logic        ok_reg, ok_next;
    logic        pres_out_reg;
    logic [15:0] sample_reg, sample_next;
    logic        emit;

    logic        accept;
    logic [7:0]  err_inc;
    logic [2:0]  shamt;
    logic [21:0] delay_raw;
    logic [21:0] delay;
    logic [31:0] fail_deadline;
    logic [31:0] probe_diff;
    logic        deadline_hit;
    logic [31:0] elapsed;
    logic        timed_out;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        err_inc       = (err_cnt_reg == adcsr_pkg::ERR_SAT) ? err_cnt_reg
                                                            : err_cnt_reg + 8'd1;
        shamt         = (err_inc > {5'd0, adcsr_pkg::MAX_SHIFT}) ? adcsr_pkg::MAX_SHIFT
                                                                 : err_inc[2:0] - 3'd1;
        delay_raw     = {6'd0, retry_base_reg} << shamt;
        delay         = (delay_raw < retry_max_reg) ? delay_raw : retry_max_reg;
        fail_deadline = now_ms + {10'd0, delay};
        probe_diff    = now_ms - next_probe_reg;
        deadline_hit  = !probe_diff[31];
        elapsed       = now_ms - conv_start_reg;
        timed_out     = elapsed >= {16'd0, conv_tmo_reg};
    end

    always_comb
    begin
        phase_next      = phase_reg;
        requester_next  = requester_reg;
        present_next    = present_reg;
        err_cnt_next    = err_cnt_reg;
        next_probe_next = next_probe_reg;
        conv_start_next = conv_start_reg;
        chan_next       = chan_reg;
        emit            = 1'b0;
        action_next     = adcsr_pkg::ACT_DONE;
        word_next       = 16'd0;
        ok_next         = 1'b0;
        sample_next     = 16'd0;

        if (func != adcsr_pkg::FN_BUS)
        begin
            if (phase_reg == adcsr_pkg::PH_IDLE)
            begin
                emit = 1'b1;
                if (func == adcsr_pkg::FN_INIT)
                begin
                    present_next    = 1'b0;
                    err_cnt_next    = 8'd0;
                    next_probe_next = 32'd0;
                    requester_next  = adcsr_pkg::FN_INIT;
                    phase_next      = adcsr_pkg::PH_PROBE;
                    action_next     = adcsr_pkg::ACT_PROBE;
                end
                else if (func == adcsr_pkg::FN_READ && channel > {1'b0, max_chan_reg})
                begin
                    action_next = adcsr_pkg::ACT_DONE;
                end
                else if (func == adcsr_pkg::FN_READ && present_reg)
                begin
                    chan_next   = channel[1:0];
                    phase_next  = adcsr_pkg::PH_WRITE;
                    action_next = adcsr_pkg::ACT_WRITE;
                    word_next   = adcsr_pkg::word_for(channel[1:0]);
                end
                else if (func == adcsr_pkg::FN_PRESENCE && present_reg)
                begin
                    ok_next = 1'b1;
                end
                else
                begin
                    if (func == adcsr_pkg::FN_READ)
                    begin
                        chan_next = channel[1:0];
                    end
                    if (deadline_hit)
                    begin
                        requester_next = adcsr_pkg::func_t'(func);
                        phase_next     = adcsr_pkg::PH_PROBE;
                        action_next    = adcsr_pkg::ACT_PROBE;
                    end
                end
            end
        end
        else
        begin
            case (phase_reg)
                adcsr_pkg::PH_PROBE, adcsr_pkg::PH_WRITE,
                adcsr_pkg::PH_POLL, adcsr_pkg::PH_READ:
                begin
                    emit = 1'b1;
                    if (!bus_ok || (phase_reg == adcsr_pkg::PH_POLL && !bus_data[15]
                                    && timed_out))
                    begin
                        present_next    = 1'b0;
                        err_cnt_next    = err_inc;
                        next_probe_next = fail_deadline;
                        phase_next      = adcsr_pkg::PH_IDLE;
                    end
                    else if (phase_reg == adcsr_pkg::PH_PROBE)
                    begin
                        present_next    = 1'b1;
                        err_cnt_next    = 8'd0;
                        next_probe_next = 32'd0;
                        if (requester_reg == adcsr_pkg::FN_READ)
                        begin
                            phase_next  = adcsr_pkg::PH_WRITE;
                            action_next = adcsr_pkg::ACT_WRITE;
                            word_next   = adcsr_pkg::word_for(chan_reg);
                        end
                        else
                        begin
                            phase_next = adcsr_pkg::PH_IDLE;
                            ok_next    = 1'b1;
                        end
                    end
                    else if (phase_reg == adcsr_pkg::PH_WRITE)
                    begin
                        conv_start_next = now_ms;
                        phase_next      = adcsr_pkg::PH_POLL;
                        action_next     = adcsr_pkg::ACT_POLL;
                    end
                    else if (phase_reg == adcsr_pkg::PH_POLL)
                    begin
                        if (bus_data[15])
                        begin
                            phase_next  = adcsr_pkg::PH_READ;
                            action_next = adcsr_pkg::ACT_CONV;
                        end
                        else
                        begin
                            action_next = adcsr_pkg::ACT_POLL;
                        end
                    end
                    else
                    begin
                        present_next    = 1'b1;
                        err_cnt_next    = 8'd0;
                        next_probe_next = 32'd0;
                        phase_next      = adcsr_pkg::PH_IDLE;
                        ok_next         = 1'b1;
                        sample_next     = bus_data;
                    end
                end
                default:
                begin
                    phase_next = adcsr_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_base_reg <= adcsr_pkg::RETRY_BASE_RST;
            retry_max_reg  <= adcsr_pkg::RETRY_MAX_RST;
            conv_tmo_reg   <= adcsr_pkg::CONV_TMO_RST;
            max_chan_reg   <= adcsr_pkg::MAX_CHAN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (adcsr_pkg::reg_index_t'(cfg_index))
                adcsr_pkg::REG_RETRY_BASE: retry_base_reg <= cfg_data[15:0];
                adcsr_pkg::REG_RETRY_MAX:  retry_max_reg  <= cfg_data;
                adcsr_pkg::REG_CONV_TMO:   conv_tmo_reg   <= cfg_data[15:0];
                adcsr_pkg::REG_MAX_CHAN:   max_chan_reg   <= cfg_data[1:0];
                default:                   max_chan_reg   <= max_chan_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= adcsr_pkg::PH_IDLE;
            requester_reg  <= adcsr_pkg::FN_INIT;
            present_reg    <= 1'b0;
            err_cnt_reg    <= 8'd0;
            next_probe_reg <= 32'd0;
            conv_start_reg <= 32'd0;
            chan_reg       <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                requester_reg  <= requester_next;
                present_reg    <= present_next;
                err_cnt_reg    <= err_cnt_next;
                next_probe_reg <= next_probe_next;
                conv_start_reg <= conv_start_next;
                chan_reg       <= chan_next;
            end
            if (accept && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            action_reg   <= action_next;
            word_reg     <= word_next;
            ok_reg       <= ok_next;
            pres_out_reg <= present_next;
            sample_reg   <= sample_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign action      = action_reg;
    assign config_word = word_reg;
    assign done_ok     = ok_reg;
    assign present     = pres_out_reg;
    assign sample      = sample_reg;

    a_present_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (pres_out_reg == present_reg))
        else $error("pending transaction presence differs from state");

    a_err_implies_absent: assert property (@(posedge clk) disable iff (!rst_n)
        (err_cnt_reg != 8'd0) |-> !present_reg)
        else $error("error count set while device present");

    a_done_iff_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((action_reg == adcsr_pkg::ACT_DONE) ==
                           (phase_reg == adcsr_pkg::PH_IDLE)))
        else $error("finish action does not match idle phase");

    a_probe_clears_on_success: assert property (@(posedge clk) disable iff (!rst_n)
        present_reg |-> (next_probe_reg == 32'd0))
        else $error("backoff deadline kept while device present");

endmodule
